FILE: src/rbsh_pkg.sv
// Shared types and constants of the segment-versus-box hit block.
`timescale 1ns / 1ps
`default_nettype none
package rbsh_pkg;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned HW = 31;
  localparam int unsigned GW = 2 * HW - FRAC_BITS;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PW = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] FACE_NX = 3'd0;
  localparam logic [2:0] FACE_PX = 3'd1;
  localparam logic [2:0] FACE_NY = 3'd2;
  localparam logic [2:0] FACE_PY = 3'd3;
  localparam logic [2:0] FACE_NZ = 3'd4;
  localparam logic [2:0] FACE_PZ = 3'd5;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
    logic [30:0]        probe_diameter;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic [2:0]         face;
    logic [31:0]        distance;
  } out_t;

  // classified transaction passed from front to back
  typedef struct packed {
    logic [2:0][31:0]   org;
    logic [2:0][31:0]   dabs;
    logic [2:0]         dneg;
    logic [2:0][HW-1:0] half;
    logic [2:0][61:0]   gprod;
    logic [5:0]         ok;
    logic [5:0][31:0]   a;
  } fe_t;

  function automatic logic [1:0] other_axis(input logic [1:0] ax, input logic j);
    logic [1:0] r;
    case (ax)
      2'd0:    r = j ? 2'd2 : 2'd1;
      2'd1:    r = j ? 2'd2 : 2'd0;
      default: r = j ? 2'd1 : 2'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: src/ray_box_segment_hit_top.sv
// Top level of the segment-versus-centred-box hit block.
//
// Input channel in_valid_i/in_stall_o/in_data_i carries one segment query per
// transaction; output channel out_valid_o/out_stall_i/out_data_o returns one
// result per query, in order. A transaction completes on a clock edge with
// valid high and stall low.
// Throughput: one query per cycle, sustained while the receiver does not stall.
// The back pipeline holds one multiply stage, 32 restoring divider steps for the
// face points, the inside test, six multiply/compare pairs that pick the nearest
// face, clamp, square, sum and 32 square-root steps.
// A four-entry queue sits between front and back; while the receiver stalls
// the back pipeline holds and the front keeps taking queries until the queue
// fills, then in_stall_o rises.
// Reset (rst_ni low, asynchronous) empties the queue and drops all queries in
// flight; no result is presented until new queries arrive.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_segment_hit_top (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  rbsh_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output rbsh_pkg::out_t out_data_o
);
  rbsh_pkg::fe_t push_data, head;
  logic push, full, pop, empty;

  rbsh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  rbsh_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  rbsh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );
endmodule
`default_nettype wire

FILE: src/rbsh_fifo.sv
// Small queue between the classifying front and the compute back.
`timescale 1ns / 1ps
`default_nettype none
module rbsh_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  rbsh_pkg::fe_t     push_data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output rbsh_pkg::fe_t     head_o,
  output logic              empty_o
);
  rbsh_pkg::fe_t mem_q [rbsh_pkg::FIFO_DEPTH];
  logic [rbsh_pkg::FIFO_PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [rbsh_pkg::FIFO_CW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == rbsh_pkg::FIFO_CW'(rbsh_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? rbsh_pkg::FIFO_PW'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? rbsh_pkg::FIFO_PW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = rbsh_pkg::FIFO_CW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = rbsh_pkg::FIFO_CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end
endmodule
`default_nettype wire

FILE: src/rbsh_front.sv
// Front: accepts transactions, range-tests each face and forms the grown-box products.
`timescale 1ns / 1ps
`default_nettype none
module rbsh_front (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  rbsh_pkg::in_t  in_data_i,
  output logic           push_o,
  output rbsh_pkg::fe_t  push_data_o,
  input  wire logic      full_i
);
  logic          fr_valid_q;
  rbsh_pkg::in_t fr_q;

  assign in_stall_o = fr_valid_q && full_i;
  assign push_o     = fr_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      fr_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      fr_q <= in_data_i;
    end
  end

  always_comb begin
    logic [2:0][31:0] dl;
    logic signed [33:0] plane, num, d34;
    logic [33:0] anum;
    int ax;
    dl[0] = fr_q.delta_x;
    dl[1] = fr_q.delta_y;
    dl[2] = fr_q.delta_z;
    push_data_o.org[0]  = fr_q.origin_x;
    push_data_o.org[1]  = fr_q.origin_y;
    push_data_o.org[2]  = fr_q.origin_z;
    push_data_o.half[0] = fr_q.half_x;
    push_data_o.half[1] = fr_q.half_y;
    push_data_o.half[2] = fr_q.half_z;
    for (int k = 0; k < 3; k++) begin
      push_data_o.dneg[k]  = dl[k][31];
      push_data_o.dabs[k]  = dl[k][31] ? 32'(-dl[k]) : dl[k];
      push_data_o.gprod[k] = 62'(push_data_o.half[k]) * 62'(fr_q.probe_diameter);
    end
    for (int f = 0; f < 6; f++) begin
      ax    = f / 2;
      plane = (f % 2 == 1) ? $signed({3'b000, push_data_o.half[ax]})
                           : -$signed({3'b000, push_data_o.half[ax]});
      num   = plane - $signed({{2{push_data_o.org[ax][31]}}, push_data_o.org[ax]});
      d34   = $signed({{2{dl[ax][31]}}, dl[ax]});
      anum  = num[33] ? 34'(-num) : 34'(num);
      push_data_o.ok[f] = (dl[ax] != '0) &&
                          (dl[ax][31] ? (num <= 0 && num >= d34) : (num >= 0 && num <= d34));
      push_data_o.a[f]  = push_data_o.ok[f] ? anum[31:0] : 32'd0;
    end
  end
endmodule
`default_nettype wire

FILE: src/rbsh_back.sv
// Back: face-point dividers, inside test, nearest-face pick, distance root.
`timescale 1ns / 1ps
`default_nettype none
module rbsh_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  rbsh_pkg::fe_t  head_i,
  input  wire logic      empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output rbsh_pkg::out_t out_data_o
);
  localparam int ST_MUL  = 1;
  localparam int ST_DIV0 = 2;
  localparam int ST_PT   = ST_DIV0 + 32;
  localparam int ST_SEL0 = ST_PT + 1;
  localparam int ST_CLMP = ST_SEL0 + 12;
  localparam int ST_SQ   = ST_CLMP + 1;
  localparam int ST_SUM  = ST_SQ + 1;
  localparam int ST_RT0  = ST_SUM + 1;
  localparam int NST     = ST_RT0 + 32;

  typedef struct packed {
    rbsh_pkg::fe_t                 fe;
    logic [2:0][rbsh_pkg::GW-1:0]  grown;
    logic [5:0][1:0][62:0]         num;
    logic [5:0][1:0][32:0]         rem;
    logic [5:0][1:0][31:0]         quo;
    logic [5:0][2:0][32:0]         pt;
    logic [5:0]                    fv;
    logic [63:0]                   pa;
    logic [63:0]                   pb;
    logic                          have;
    logic [31:0]                   best_a;
    logic [31:0]                   best_b;
    logic [2:0]                    bface;
    logic [2:0][32:0]              bpt;
    logic [2:0][31:0]              dd;
    logic [2:0][63:0]              sq;
    logic [63:0]                   sum;
    logic                          sat;
    logic [31:0]                   root;
    logic [35:0]                   rrem;
  } bk_t;

  bk_t  pipe_q [NST];
  bk_t  nxt    [NST];
  logic [NST-1:0] v_q;
  logic en;
  logic out_valid_q;
  rbsh_pkg::out_t out_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    nxt[0]    = '0;
    nxt[0].fe = head_i;
  end

  for (genvar s = 1; s < NST; s++) begin : g_st
    if (s == ST_MUL) begin : g_mul
      always_comb begin
        logic [1:0] k;
        nxt[s] = pipe_q[s-1];
        for (int f = 0; f < 6; f++) begin
          for (int j = 0; j < 2; j++) begin
            k = rbsh_pkg::other_axis(2'(f / 2), j[0]);
            nxt[s].num[f][j] = 63'(pipe_q[s-1].fe.dabs[k]) * 63'(pipe_q[s-1].fe.a[f]);
            nxt[s].rem[f][j] = {2'b00, nxt[s].num[f][j][62:32]};
            nxt[s].quo[f][j] = '0;
          end
        end
        for (int m = 0; m < 3; m++) begin
          nxt[s].grown[m] = rbsh_pkg::GW'(pipe_q[s-1].fe.half[m]) +
                            rbsh_pkg::GW'(pipe_q[s-1].fe.gprod[m] >> (rbsh_pkg::FRAC_BITS + 1));
        end
      end
    end else if (s >= ST_DIV0 && s < ST_PT) begin : g_div
      always_comb begin
        logic [32:0] r2, bd;
        nxt[s] = pipe_q[s-1];
        for (int f = 0; f < 6; f++) begin
          bd = {1'b0, pipe_q[s-1].fe.dabs[f/2]};
          for (int j = 0; j < 2; j++) begin
            r2 = {pipe_q[s-1].rem[f][j][31:0], pipe_q[s-1].num[f][j][31-(s-ST_DIV0)]};
            if (r2 >= bd) begin
              nxt[s].rem[f][j] = r2 - bd;
              nxt[s].quo[f][j] = {pipe_q[s-1].quo[f][j][30:0], 1'b1};
            end else begin
              nxt[s].rem[f][j] = r2;
              nxt[s].quo[f][j] = {pipe_q[s-1].quo[f][j][30:0], 1'b0};
            end
          end
        end
      end
    end else if (s == ST_PT) begin : g_pt
      always_comb begin
        logic [1:0] k;
        logic signed [32:0] o33, q33, hv;
        logic [32:0] ab;
        logic in_box;
        nxt[s] = pipe_q[s-1];
        for (int f = 0; f < 6; f++) begin
          hv = $signed({2'b00, pipe_q[s-1].fe.half[f/2]});
          nxt[s].pt[f][f/2] = (f % 2 == 1) ? hv : -hv;
          for (int j = 0; j < 2; j++) begin
            k   = rbsh_pkg::other_axis(2'(f / 2), j[0]);
            o33 = $signed({pipe_q[s-1].fe.org[k][31], pipe_q[s-1].fe.org[k]});
            q33 = $signed({1'b0, pipe_q[s-1].quo[f][j]});
            nxt[s].pt[f][k] = pipe_q[s-1].fe.dneg[k] ? o33 - q33 : o33 + q33;
          end
          in_box = 1'b1;
          for (int m = 0; m < 3; m++) begin
            ab = nxt[s].pt[f][m][32] ? 33'(-nxt[s].pt[f][m]) : nxt[s].pt[f][m];
            if (rbsh_pkg::GW'(ab) > pipe_q[s-1].grown[m]) begin
              in_box = 1'b0;
            end
          end
          nxt[s].fv[f] = pipe_q[s-1].fe.ok[f] && in_box;
        end
        nxt[s].have   = 1'b0;
        nxt[s].best_a = '0;
        nxt[s].best_b = 32'd1;
        nxt[s].bface  = rbsh_pkg::FACE_NX;
        nxt[s].bpt    = '0;
      end
    end else if (s >= ST_SEL0 && s < ST_CLMP && ((s - ST_SEL0) % 2 == 0)) begin : g_selm
      always_comb begin
        nxt[s]    = pipe_q[s-1];
        nxt[s].pa = 64'(pipe_q[s-1].fe.a[(s-ST_SEL0)/2]) * 64'(pipe_q[s-1].best_b);
        nxt[s].pb = 64'(pipe_q[s-1].best_a) * 64'(pipe_q[s-1].fe.dabs[(s-ST_SEL0)/4]);
      end
    end else if (s >= ST_SEL0 && s < ST_CLMP) begin : g_selc
      always_comb begin
        nxt[s] = pipe_q[s-1];
        if (pipe_q[s-1].fv[(s-ST_SEL0)/2] &&
            (!pipe_q[s-1].have || pipe_q[s-1].pa < pipe_q[s-1].pb)) begin
          nxt[s].have   = 1'b1;
          nxt[s].best_a = pipe_q[s-1].fe.a[(s-ST_SEL0)/2];
          nxt[s].best_b = pipe_q[s-1].fe.dabs[(s-ST_SEL0)/4];
          nxt[s].bface  = 3'((s - ST_SEL0) / 2);
          nxt[s].bpt    = pipe_q[s-1].pt[(s-ST_SEL0)/2];
        end
      end
    end else if (s == ST_CLMP) begin : g_clmp
      always_comb begin
        logic signed [32:0] hv, c;
        logic signed [33:0] df;
        nxt[s] = pipe_q[s-1];
        for (int m = 0; m < 3; m++) begin
          hv = $signed({2'b00, pipe_q[s-1].fe.half[m]});
          c  = $signed(pipe_q[s-1].bpt[m]);
          if (c < -hv) begin
            c = -hv;
          end
          if (c > hv) begin
            c = hv;
          end
          nxt[s].bpt[m] = c;
          df = $signed({c[32], c}) -
               $signed({{2{pipe_q[s-1].fe.org[m][31]}}, pipe_q[s-1].fe.org[m]});
          nxt[s].dd[m] = df[33] ? 32'(-df) : df[31:0];
        end
      end
    end else if (s == ST_SQ) begin : g_sq
      always_comb begin
        nxt[s] = pipe_q[s-1];
        for (int m = 0; m < 3; m++) begin
          nxt[s].sq[m] = 64'(pipe_q[s-1].dd[m]) * 64'(pipe_q[s-1].dd[m]);
        end
      end
    end else if (s == ST_SUM) begin : g_sum
      always_comb begin
        logic [65:0] s66;
        nxt[s] = pipe_q[s-1];
        s66 = 66'(pipe_q[s-1].sq[0]) + 66'(pipe_q[s-1].sq[1]) + 66'(pipe_q[s-1].sq[2]);
        nxt[s].sat  = |s66[65:64];
        nxt[s].sum  = s66[63:0];
        nxt[s].root = '0;
        nxt[s].rrem = '0;
      end
    end else begin : g_rt
      always_comb begin
        logic [35:0] r, trial;
        nxt[s] = pipe_q[s-1];
        r     = {pipe_q[s-1].rrem[33:0], pipe_q[s-1].sum[63-2*(s-ST_RT0) -: 2]};
        trial = {2'b00, pipe_q[s-1].root, 2'b01};
        if (r >= trial) begin
          nxt[s].rrem = r - trial;
          nxt[s].root = {pipe_q[s-1].root[30:0], 1'b1};
        end else begin
          nxt[s].rrem = r;
          nxt[s].root = {pipe_q[s-1].root[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[NST-2:0], !empty_i};
      out_valid_q <= v_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NST; s++) begin
        pipe_q[s] <= nxt[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pipe_q[NST-1].have) begin
        out_q.hit      <= 1'b1;
        out_q.hit_x    <= pipe_q[NST-1].bpt[0][31:0];
        out_q.hit_y    <= pipe_q[NST-1].bpt[1][31:0];
        out_q.hit_z    <= pipe_q[NST-1].bpt[2][31:0];
        out_q.face     <= pipe_q[NST-1].bface;
        out_q.distance <= pipe_q[NST-1].sat ? 32'hFFFF_FFFF : pipe_q[NST-1].root;
      end else begin
        out_q <= '0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/rbsh_checker.sv
// Port-level checker for the hit block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rbsh_sva (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire rbsh_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire rbsh_pkg::out_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.hit_x == 0 && out_data_o.hit_y == 0 &&
      out_data_o.hit_z == 0 && out_data_o.face == rbsh_pkg::FACE_NX &&
      out_data_o.distance == 0)
    else $error("miss with nonzero fields");

  a_face_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.face <= rbsh_pkg::FACE_PZ)
    else $error("bad face code");

  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");
endmodule

bind ray_box_segment_hit_top rbsh_sva u_chk (.*);
`default_nettype wire

FILE: tb/rbsh_checker.sv
// Checker for the segment-versus-box hit block: predicts results and compares.
`timescale 1ns / 1ps
module rbsh_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  rbsh_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  rbsh_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  rbsh_pkg::out_t hit_queue[$];

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] rem, res, bit_v;
    rem = v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic rbsh_pkg::out_t predict_hit(input rbsh_pkg::in_t q);
    longint org[3], dlt[3], half[3], grown[3], best_pt[3], pt[3];
    longint plane, num, c;
    logic [63:0] diam, best_a, best_b, a, b, off, h, sum, d, sq, dist_v;
    logic have, in_box, sat;
    logic [2:0] best_face;
    rbsh_pkg::out_t r;
    diam = 64'(q.probe_diameter);
    org[0] = q.origin_x; org[1] = q.origin_y; org[2] = q.origin_z;
    dlt[0] = q.delta_x; dlt[1] = q.delta_y; dlt[2] = q.delta_z;
    half[0] = q.half_x; half[1] = q.half_y; half[2] = q.half_z;
    for (int k = 0; k < 3; k++) begin
      h = 64'(half[k]);
      grown[k] = longint'(h + ((h * diam) >> (rbsh_pkg::FRAC_BITS + 1)));
      best_pt[k] = 0;
    end
    best_a = 0;
    best_b = 1;
    have = 0;
    best_face = rbsh_pkg::FACE_NX;
    for (int ax = 0; ax < 3; ax++) begin
      if (dlt[ax] == 0) continue;
      for (int side = 0; side < 2; side++) begin
        plane = side ? half[ax] : -half[ax];
        num = plane - org[ax];
        if (dlt[ax] > 0) begin
          if (num < 0 || num > dlt[ax]) continue;
        end else begin
          if (num > 0 || num < dlt[ax]) continue;
        end
        a = mag(num);
        b = mag(dlt[ax]);
        if (have && !(a * best_b < best_a * b)) continue;
        in_box = 1;
        for (int k = 0; k < 3; k++) begin
          if (k == ax) pt[k] = plane;
          else begin
            off = (mag(dlt[k]) * a) / b;
            pt[k] = dlt[k] < 0 ? org[k] - longint'(off) : org[k] + longint'(off);
          end
          if (longint'(mag(pt[k])) > grown[k]) in_box = 0;
        end
        if (!in_box) continue;
        have = 1;
        best_a = a;
        best_b = b;
        best_face = 3'(ax * 2 + side);
        for (int k = 0; k < 3; k++) best_pt[k] = pt[k];
      end
    end
    r = '0;
    if (!have) return r;
    sum = 0;
    sat = 0;
    for (int k = 0; k < 3; k++) begin
      c = best_pt[k];
      if (c < -half[k]) c = -half[k];
      if (c > half[k]) c = half[k];
      best_pt[k] = c;
      d = mag(c - org[k]);
      sq = d * d;
      if (sum + sq < sum) sat = 1;
      sum = sum + sq;
    end
    dist_v = sat ? 64'hFFFF_FFFF : isqrt(sum);
    if (dist_v > 64'hFFFF_FFFF) dist_v = 64'hFFFF_FFFF;
    r.hit = 1'b1;
    r.hit_x = best_pt[0][31:0];
    r.hit_y = best_pt[1][31:0];
    r.hit_z = best_pt[2][31:0];
    r.face = best_face;
    r.distance = dist_v[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    rbsh_pkg::out_t want;
    if (rst_ni && in_valid_i && !in_stall_i) hit_queue.push_back(predict_hit(in_data_i));
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (hit_queue.size() == 0) report_mismatch("unexpected result", 0, 0);
      else begin
        want = hit_queue.pop_front();
        if (out_data_i.hit !== want.hit) report_mismatch("hit", out_data_i.hit, want.hit);
        if (out_data_i.hit_x !== want.hit_x)
          report_mismatch("hit_x", out_data_i.hit_x, want.hit_x);
        if (out_data_i.hit_y !== want.hit_y)
          report_mismatch("hit_y", out_data_i.hit_y, want.hit_y);
        if (out_data_i.hit_z !== want.hit_z)
          report_mismatch("hit_z", out_data_i.hit_z, want.hit_z);
        if (out_data_i.face !== want.face) report_mismatch("face", out_data_i.face, want.face);
        if (out_data_i.distance !== want.distance)
          report_mismatch("distance", out_data_i.distance, want.distance);
      end
    end
    pending_o = hit_queue.size();
  end
endmodule

FILE: tb/testbench.sv
// Top of the segment-versus-box hit testbench: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 0;
  logic in_stall_o, out_valid_o;
  rbsh_pkg::in_t in_data_i = '0;
  rbsh_pkg::out_t out_data_o;
  int fail_count, pending;
  int send_idle = 0, recv_idle = 0;
  int hold_cycles = 0;
  int cycles = 0;
  localparam int LIMIT = 400000;

  ray_box_segment_hit_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_data_i(in_data_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  rbsh_checker checker_inst (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_i(in_stall_o),
    .in_data_i(in_data_i), .out_valid_i(out_valid_o), .out_stall_i(out_stall_i),
    .out_data_i(out_data_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: long hold-off has priority over random stalls
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endcase
  endfunction

  function automatic rbsh_pkg::in_t random_query();
    rbsh_pkg::in_t q;
    int mode;
    mode = int'($urandom_range(9));
    q.origin_x = rand_coord(mode == 0 ? 0 : 2);
    q.origin_y = rand_coord(mode == 0 ? 0 : 2);
    q.origin_z = rand_coord(mode == 0 ? 0 : 2);
    q.delta_x = rand_coord(mode == 0 ? 0 : 2) * 2;
    q.delta_y = rand_coord(mode == 0 ? 0 : 2) * 2;
    q.delta_z = rand_coord(mode == 0 ? 0 : 2) * 2;
    if (mode == 1) begin
      q.delta_x = -q.origin_x + rand_coord(1);
      q.delta_y = -q.origin_y + rand_coord(1);
      q.delta_z = -q.origin_z + rand_coord(1);
    end
    if ($urandom_range(15) == 0) q.delta_x = 0;
    if ($urandom_range(15) == 0) q.delta_y = 0;
    if ($urandom_range(15) == 0) q.delta_z = 0;
    if (mode == 0) begin
      q.half_x = 31'($urandom); q.half_y = 31'($urandom); q.half_z = 31'($urandom);
      q.probe_diameter = 31'($urandom);
    end else begin
      q.half_x = 31'($urandom_range(32'h0080_0000));
      q.half_y = 31'($urandom_range(32'h0080_0000));
      q.half_z = 31'($urandom_range(32'h0080_0000));
      q.probe_diameter = ($urandom_range(3) == 0) ? 31'($urandom)
                                                  : 31'($urandom_range(32'h0004_0000));
    end
    return q;
  endfunction

  task automatic send_query(input rbsh_pkg::in_t q);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic rbsh_pkg::in_t make_query(input logic [31:0] ox, oy, oz, dx, dy, dz,
                                               input logic [30:0] hx, hy, hz, pd);
    rbsh_pkg::in_t q;
    q.origin_x = ox; q.origin_y = oy; q.origin_z = oz;
    q.delta_x = dx; q.delta_y = dy; q.delta_z = dz;
    q.half_x = hx; q.half_y = hy; q.half_z = hz; q.probe_diameter = pd;
    return q;
  endfunction

  initial begin
    rbsh_pkg::in_t dq[$];
    localparam logic [31:0] ONE = 32'h0001_0000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // each face, misses, zero delta, ties, extremes, saturation
    dq.push_back(make_query(-3*ONE, 0, 0, 6*ONE, 0, 0, ONE, ONE, ONE, 0));
    dq.push_back(make_query(3*ONE, 0, 0, -6*ONE, 0, 0, ONE, ONE, ONE, 0));
    dq.push_back(make_query(0, -3*ONE, 0, 0, 6*ONE, 0, ONE, ONE, ONE, 0));
    dq.push_back(make_query(0, 3*ONE, 0, 0, -6*ONE, 0, ONE, ONE, ONE, 0));
    dq.push_back(make_query(0, 0, -3*ONE, 0, 0, 6*ONE, ONE, ONE, ONE, 0));
    dq.push_back(make_query(0, 0, 3*ONE, 0, 0, -6*ONE, ONE, ONE, ONE, 0));
    dq.push_back(make_query(0, 0, 0, 0, 0, 0, ONE, ONE, ONE, ONE));
    dq.push_back(make_query(-3*ONE, -3*ONE, 0, 6*ONE, 6*ONE, 0, ONE, ONE, ONE, 0));
    dq.push_back(make_query(-3*ONE, 5*ONE, 0, 6*ONE, 0, 0, ONE, ONE, ONE, 0));
    dq.push_back(make_query(-3*ONE, 3*ONE/2, 0, 6*ONE, 0, 0, ONE, ONE, ONE, 2*ONE));
    dq.push_back(make_query(0, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
    dq.push_back(make_query(-3*ONE, 0, 0, ONE, 0, 0, ONE, ONE, ONE, 0));
    dq.push_back(make_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    dq.push_back(make_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0));
    dq.push_back(make_query(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                            31'h1000_0000, 31'h7FFF_FFFF, 0, 31'h7FFF_FFFF));
    dq.push_back(make_query(-ONE, 0, 0, 2*ONE, 0, 0, ONE, 0, 0, 0));
    foreach (dq[i]) send_query(dq[i]);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 49; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 49; end
        3: begin send_idle = 8; recv_idle = 8; end
        default: begin send_idle = 0; recv_idle = 0; hold_cycles <= 300; end
      endcase
      repeat (380) send_query(random_query());
    end
    in_valid_i <= 1'b0;
    send_idle = 0;
    recv_idle = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
